@@ hw/rtl/bracket_timestamp_max_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Bracket timestamp max tracker - assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef BRACKET_TIMESTAMP_MAX_TRACKER_ASSERT_SVH
`define BRACKET_TIMESTAMP_MAX_TRACKER_ASSERT_SVH

// Same-cycle implication (or plain property), disabled while in reset.
`define BTMT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btmt: assertion failed");

// Next-cycle implication, disabled while in reset.
`define BTMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btmt: assertion failed");

`endif

@@ hw/rtl/btmt_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket timestamp max tracker - package
// Widths, character codes, limits and the group state type.
// ----------------------------------------------------------------------------
package btmt_pkg;

    // Field and state widths
    localparam int BYTE_W = 8;
    localparam int INT_W  = 20;
    localparam int FRAC_W = 10;
    localparam int MS_W   = 30;
    localparam int LEN_W  = 6;
    localparam int DOT_W  = 2;
    localparam int FCNT_W = 2;

    // Limits
    localparam int TAIL_LIMIT  = 32;
    localparam int FRAC_DIGITS = 3;
    localparam logic [LEN_W-1:0] LEN_MAX     = '1;
    localparam logic [INT_W-1:0] INT_SEC_MAX = '1;
    localparam logic [DOT_W-1:0] DOT_MAX     = DOT_W'(2);
    localparam logic [MS_W-1:0]  MS_PER_SEC  = MS_W'(1000);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    // Running state of the group being parsed
    typedef struct packed {
        logic              open;
        logic [LEN_W-1:0]  len;
        logic [INT_W-1:0]  int_sec;
        logic [FRAC_W-1:0] frac;
        logic [FCNT_W-1:0] frac_cnt;
        logic [DOT_W-1:0]  dot_cnt;
        logic              has_digit;
        logic              bad;
    } t_group;

    // Scale for the kept fraction digits: 10^(3 - count)
    function automatic logic [FRAC_W-1:0] frac_scale(input logic [FCNT_W-1:0] cnt);
        logic [FRAC_W-1:0] scale;
        case (cnt)
            2'd0:    scale = FRAC_W'(1000);
            2'd1:    scale = FRAC_W'(100);
            2'd2:    scale = FRAC_W'(10);
            default: scale = FRAC_W'(1);
        endcase
        return scale;
    endfunction

endpackage

@@ hw/rtl/bracket_timestamp_max_tracker.sv @@
// ----------------------------------------------------------------------------
// Bracket timestamp max tracker
// Scans a text byte stream for numeric bracket groups and tracks the maximum.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output side is ready, and returns one
// result word per byte, in order. A byte passes through the input register,
// then the parse/result register; with the output side ready, a new byte is
// taken every cycle. The rate is set by the group-state update, which reads
// and writes the running group and maximum registers for each byte. A group
// value is seconds * 1000 + fraction scaled to ms; "[]" and groups with any
// byte other than digits and dots are not reported. After a byte marked end
// of token, an open group begun more than 32 bytes back is dropped.
module bracket_timestamp_max_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input words
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [btmt_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                        i_end_of_token,
    // result words
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [btmt_pkg::MS_W-1:0]   o_max_timestamp_ms,
    output logic                        o_group_accepted,
    output logic [btmt_pkg::MS_W-1:0]   o_group_ms
);

    // Input register
    logic                        r_in_valid;
    logic [btmt_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_eot;

    // Running state
    btmt_pkg::t_group            r_grp, n_grp;
    logic [btmt_pkg::MS_W-1:0]   r_best, n_best;

    // Result register
    logic                        r_out_valid;
    logic                        r_out_acc, n_out_acc;
    logic [btmt_pkg::MS_W-1:0]   r_out_max;
    logic [btmt_pkg::MS_W-1:0]   r_out_gms, n_out_gms;

    logic out_free;
    logic advance;
    logic is_digit;
    logic [3:0]                  digit;
    logic [btmt_pkg::INT_W+3:0]  int_next;
    logic [btmt_pkg::MS_W-1:0]   gms;

    // Handshake: result slot frees when empty or taken
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_token;
        end
    end

    // Byte decode and running arithmetic
    assign is_digit = (r_in_byte >= btmt_pkg::CH_ZERO) && (r_in_byte <= btmt_pkg::CH_NINE);
    assign digit    = 4'(r_in_byte - btmt_pkg::CH_ZERO);
    assign int_next = (btmt_pkg::INT_W+4)'(r_grp.int_sec) * (btmt_pkg::INT_W+4)'(10)
                    + (btmt_pkg::INT_W+4)'(digit);
    assign gms      = btmt_pkg::MS_W'(r_grp.int_sec) * btmt_pkg::MS_PER_SEC
                    + btmt_pkg::MS_W'(r_grp.frac)
                    * btmt_pkg::MS_W'(btmt_pkg::frac_scale(r_grp.frac_cnt));

    // Next group state and result
    always_comb begin
        n_grp     = r_grp;
        n_best    = r_best;
        n_out_acc = 1'b0;
        n_out_gms = '0;
        if (r_in_byte == btmt_pkg::CH_OPEN) begin
            n_grp      = '0;
            n_grp.open = 1'b1;
            n_grp.len  = btmt_pkg::LEN_W'(1);
        end else if (r_in_byte == btmt_pkg::CH_CLOSE) begin
            if (r_grp.open && !r_grp.bad && r_grp.has_digit) begin
                n_out_acc = 1'b1;
                n_out_gms = gms;
                if (gms > r_best) begin
                    n_best = gms;
                end
            end
            n_grp = '0;
        end else if (r_grp.open) begin
            if (r_grp.len != btmt_pkg::LEN_MAX) begin
                n_grp.len = r_grp.len + btmt_pkg::LEN_W'(1);
            end
            if (is_digit) begin
                n_grp.has_digit = 1'b1;
                if (r_grp.dot_cnt == '0) begin
                    n_grp.int_sec = (int_next > (btmt_pkg::INT_W+4)'(btmt_pkg::INT_SEC_MAX))
                                  ? btmt_pkg::INT_SEC_MAX : int_next[btmt_pkg::INT_W-1:0];
                end else if ((r_grp.dot_cnt == btmt_pkg::DOT_W'(1))
                          && (r_grp.frac_cnt < btmt_pkg::FCNT_W'(btmt_pkg::FRAC_DIGITS))) begin
                    n_grp.frac     = btmt_pkg::FRAC_W'(r_grp.frac * btmt_pkg::FRAC_W'(10))
                                   + btmt_pkg::FRAC_W'(digit);
                    n_grp.frac_cnt = r_grp.frac_cnt + btmt_pkg::FCNT_W'(1);
                end
            end else if (r_in_byte == btmt_pkg::CH_DOT) begin
                if (r_grp.dot_cnt < btmt_pkg::DOT_MAX) begin
                    n_grp.dot_cnt = r_grp.dot_cnt + btmt_pkg::DOT_W'(1);
                end
            end else begin
                n_grp.bad = 1'b1;
            end
        end
        // Tail bound at token end
        if (r_in_eot && n_grp.open && (n_grp.len > btmt_pkg::LEN_W'(btmt_pkg::TAIL_LIMIT))) begin
            n_grp = '0;
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp       <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_grp  <= n_grp;
                r_best <= n_best;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_acc <= n_out_acc;
            r_out_gms <= n_out_gms;
            r_out_max <= n_best;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_max_timestamp_ms = r_out_max;
    assign o_group_accepted   = r_out_acc;
    assign o_group_ms         = r_out_gms;

endmodule

@@ hw/rtl/btmt_checker.sv @@
// ----------------------------------------------------------------------------
// Bracket timestamp max tracker - port checker
// Watches the top level's ports and flags illegal result sequences.
// ----------------------------------------------------------------------------
`include "bracket_timestamp_max_tracker_assert.svh"

module btmt_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [btmt_pkg::MS_W-1:0] o_max_timestamp_ms,
    input logic                      o_group_accepted,
    input logic [btmt_pkg::MS_W-1:0] o_group_ms
);

    // A stalled result word stays offered
    `BTMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // No value unless a group was taken
    `BTMT_ASSERT(a_gms_zero, i_clk, i_rst_n, (o_valid && !o_group_accepted) |-> (o_group_ms == '0))

    // The running maximum covers the group just closed
    `BTMT_ASSERT(a_max_covers, i_clk, i_rst_n, (o_valid && o_group_accepted) |-> (o_max_timestamp_ms >= o_group_ms))

    // The running maximum never goes down between offered words
    `BTMT_ASSERT(a_max_mono, i_clk, i_rst_n, ($past(o_valid) && o_valid) |-> (o_max_timestamp_ms >= $past(o_max_timestamp_ms)))

    // Values stay in range: saturated seconds plus three fraction digits
    `BTMT_ASSERT(a_max_range, i_clk, i_rst_n, o_valid |-> (o_max_timestamp_ms <= 30'd1048575999))

endmodule

bind bracket_timestamp_max_tracker btmt_checker u_btmt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_max_timestamp_ms (o_max_timestamp_ms),
    .o_group_accepted   (o_group_accepted),
    .o_group_ms         (o_group_ms)
);
